### rtl/core/priority_ordered_object_stack_defines.svh
// Assertion macros shared by the priority-ordered object stack RTL.
// The macros expect signals named clk and rst_n in the module that uses them.
`ifndef PRIORITY_ORDERED_OBJECT_STACK_DEFINES_SVH
`define PRIORITY_ORDERED_OBJECT_STACK_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define POOS_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("priority ordered object stack assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define POOS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("priority ordered object stack assertion failed");

`endif

### rtl/core/poos_pkg.sv
// Types and constants for the priority-ordered object stack.
// Used by the top level; has no dependencies of its own.
`default_nettype none

package poos_pkg;

    localparam int OBJECT_BITS = 32;
    localparam int PRIO_W = 8;
    localparam int POS_W = 8;
    localparam int FUNC_W = 3;
    localparam int COUNT_OUT_W = 4;
    localparam logic [PRIO_W-1:0] CREATURE_PRIO = 8'd4;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT    = 3'd0,
        FUNC_REMOVE    = 3'd1,
        FUNC_OVERWRITE = 3'd2,
        FUNC_READ      = 3'd3,
        FUNC_CLEAR     = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_MOVE,
        ST_PLACE,
        ST_READ_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [FUNC_W-1:0]      func;
        logic                   at_top;
        logic [POS_W-1:0]       position;
        logic [OBJECT_BITS-1:0] object_word;
        logic [PRIO_W-1:0]      object_priority;
        logic                   is_creature;
    } in_item_t;

    typedef struct packed {
        logic                   status;
        logic [OBJECT_BITS-1:0] read_object;
        logic [COUNT_OUT_W-1:0] entry_count;
    } out_item_t;

    typedef struct packed {
        logic [OBJECT_BITS-1:0] word;
        logic [PRIO_W-1:0]      prio;
        logic                   creature;
    } entry_t;

    function automatic logic [PRIO_W-1:0] eff_prio(input logic [PRIO_W-1:0] prio,
                                                   input logic creature);
        return creature ? CREATURE_PRIO : prio;
    endfunction

endpackage

`default_nettype wire

### rtl/core/poos_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package needed.
`default_nettype none

module poos_ram #(
    parameter int WIDTH = 41,
    parameter int DEPTH = 10
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/core/priority_ordered_object_stack.sv
// Top level of the priority-ordered object stack: sequencer, count and mode registers.
// Depends on poos_pkg, poos_ram and priority_ordered_object_stack_defines.svh.
//
//   Channel | Direction | Handshake           | Payload
//   in      | input     | in_valid / in_ready | in_data  (poos_pkg::in_item_t)
//   out     | output    | out_valid/out_ready | out_data (poos_pkg::out_item_t)
//   cfg     | input     | cfg_valid/cfg_ready | cfg_data (modern_mode)
//
// Reset clears the count, the mode and all handshake state; the RAM needs no clearing.
// One item is worked at a time; in_ready is high only while the sequencer is idle.
// A finished result waits in the output register while the next item is accepted.
`default_nettype none
`include "priority_ordered_object_stack_defines.svh"

module priority_ordered_object_stack #(
    parameter int SLOTS = 10
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire poos_pkg::in_item_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output poos_pkg::out_item_t     out_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_data
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int ENTRY_W = $bits(poos_pkg::entry_t);

    poos_pkg::state_t    state_reg, state_next;
    poos_pkg::in_item_t  item_reg;
    logic                mode_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    tgt_reg, tgt_next;
    logic                up_reg, up_next;
    logic                rd_active_reg, rd_active_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]    pend_addr_reg, pend_addr_next;
    logic                chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]    chk_idx_reg, chk_idx_next;
    logic                status_reg, status_next;
    logic [poos_pkg::OBJECT_BITS-1:0] rword_reg, rword_next;
    logic                out_valid_reg, out_valid_next;
    poos_pkg::out_item_t res_reg, res_next;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [IDX_W-1:0]    ram_raddr;
    poos_pkg::entry_t    wr_entry;
    logic [ENTRY_W-1:0]  rd_bits;
    poos_pkg::entry_t    rd_entry;

    logic                       accept;
    logic                       full;
    logic [IDX_W-1:0]           n_top;
    logic [IDX_W-1:0]           last_idx;
    logic [poos_pkg::POS_W-1:0] cnt_pos;
    logic [poos_pkg::POS_W-1:0] slots_pos;
    logic [IDX_W-1:0]           rr_pos;
    poos_pkg::entry_t           new_obj;
    logic [poos_pkg::PRIO_W-1:0] new_eff;
    logic [poos_pkg::PRIO_W-1:0] old_eff;
    logic                       hit;

    assign in_ready  = (state_reg == poos_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;

    assign full      = (count_reg == CNT_W'(SLOTS));
    assign n_top     = full ? IDX_W'(SLOTS - 1) : IDX_W'(count_reg);
    assign last_idx  = IDX_W'(count_reg - CNT_W'(1));
    assign cnt_pos   = poos_pkg::POS_W'(count_reg);
    assign slots_pos = poos_pkg::POS_W'(SLOTS);
    assign rr_pos    = (item_reg.position >= cnt_pos) ? last_idx : IDX_W'(item_reg.position);

    assign new_obj.word     = item_reg.object_word;
    assign new_obj.prio     = item_reg.object_priority;
    assign new_obj.creature = item_reg.is_creature;

    assign rd_entry = poos_pkg::entry_t'(rd_bits);
    assign new_eff  = poos_pkg::eff_prio(item_reg.object_priority, item_reg.is_creature);
    assign old_eff  = poos_pkg::eff_prio(rd_entry.prio, rd_entry.creature);
    assign hit      = (item_reg.is_creature && mode_reg) ? (old_eff > new_eff)
                                                         : (old_eff >= new_eff);

    poos_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_entry),
        .raddr (ram_raddr),
        .rdata (rd_bits)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= poos_pkg::ST_IDLE;
            mode_reg       <= 1'b0;
            count_reg      <= '0;
            up_reg         <= 1'b0;
            rd_active_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            chk_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            up_reg         <= up_next;
            rd_active_reg  <= rd_active_next;
            pend_valid_reg <= pend_valid_next;
            chk_valid_reg  <= chk_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
        end
        idx_reg       <= idx_next;
        tgt_reg       <= tgt_next;
        pend_addr_reg <= pend_addr_next;
        chk_idx_reg   <= chk_idx_next;
        status_reg    <= status_next;
        rword_reg     <= rword_next;
        res_reg       <= res_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        tgt_next        = tgt_reg;
        up_next         = up_reg;
        rd_active_next  = rd_active_reg;
        pend_valid_next = pend_valid_reg;
        pend_addr_next  = pend_addr_reg;
        chk_valid_next  = chk_valid_reg;
        chk_idx_next    = chk_idx_reg;
        status_next     = status_reg;
        rword_next      = rword_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        res_next        = res_reg;
        ram_we          = 1'b0;
        ram_waddr       = pend_addr_reg;
        wr_entry        = rd_entry;
        ram_raddr       = idx_reg;

        unique case (state_reg)
            poos_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    status_next = 1'b0;
                    rword_next  = '0;
                    state_next  = poos_pkg::ST_DISPATCH;
                end
            end

            poos_pkg::ST_DISPATCH:
            begin
                state_next = poos_pkg::ST_DONE;
                unique case (item_reg.func) inside
                    poos_pkg::FUNC_INSERT:
                    begin
                        if (item_reg.at_top)
                        begin
                            if (count_reg == '0)
                            begin
                                tgt_next   = '0;
                                state_next = poos_pkg::ST_PLACE;
                            end
                            else
                            begin
                                idx_next       = '0;
                                chk_valid_next = 1'b0;
                                state_next     = poos_pkg::ST_SCAN;
                            end
                        end
                        else if (item_reg.position > cnt_pos || item_reg.position >= slots_pos)
                        begin
                            status_next = 1'b1;
                        end
                        else
                        begin
                            tgt_next = IDX_W'(item_reg.position);
                            if (n_top > IDX_W'(item_reg.position))
                            begin
                                idx_next        = n_top - IDX_W'(1);
                                up_next         = 1'b1;
                                rd_active_next  = 1'b1;
                                pend_valid_next = 1'b0;
                                state_next      = poos_pkg::ST_MOVE;
                            end
                            else
                            begin
                                state_next = poos_pkg::ST_PLACE;
                            end
                        end
                    end

                    poos_pkg::FUNC_REMOVE,
                    poos_pkg::FUNC_READ:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = 1'b1;
                        end
                        else if (item_reg.position >= cnt_pos && mode_reg)
                        begin
                            status_next = 1'b1;
                        end
                        else if (item_reg.func == poos_pkg::FUNC_READ)
                        begin
                            ram_raddr  = rr_pos;
                            state_next = poos_pkg::ST_READ_WAIT;
                        end
                        else if (CNT_W'(rr_pos) + CNT_W'(1) < count_reg)
                        begin
                            idx_next        = rr_pos + IDX_W'(1);
                            up_next         = 1'b0;
                            rd_active_next  = 1'b1;
                            pend_valid_next = 1'b0;
                            state_next      = poos_pkg::ST_MOVE;
                        end
                        else
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end

                    poos_pkg::FUNC_OVERWRITE:
                    begin
                        if (item_reg.position >= (mode_reg ? cnt_pos : slots_pos))
                        begin
                            status_next = 1'b1;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = IDX_W'(item_reg.position);
                            wr_entry  = new_obj;
                        end
                    end

                    poos_pkg::FUNC_CLEAR:
                    begin
                        count_next = '0;
                    end

                    default:
                    begin
                        state_next = poos_pkg::ST_DONE;
                    end
                endcase
            end

            poos_pkg::ST_SCAN:
            begin
                if (chk_valid_reg && hit)
                begin
                    tgt_next = chk_idx_reg;
                    if (n_top > chk_idx_reg)
                    begin
                        idx_next        = n_top - IDX_W'(1);
                        up_next         = 1'b1;
                        rd_active_next  = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = poos_pkg::ST_MOVE;
                    end
                    else
                    begin
                        state_next = poos_pkg::ST_PLACE;
                    end
                end
                else if (chk_valid_reg && chk_idx_reg == last_idx)
                begin
                    if (full)
                    begin
                        state_next = poos_pkg::ST_DONE;
                    end
                    else
                    begin
                        tgt_next   = IDX_W'(count_reg);
                        state_next = poos_pkg::ST_PLACE;
                    end
                end
                else
                begin
                    ram_raddr      = idx_reg;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = idx_reg;
                    idx_next       = idx_reg + IDX_W'(1);
                end
            end

            poos_pkg::ST_MOVE:
            begin
                if (pend_valid_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_addr_reg;
                    wr_entry  = rd_entry;
                end
                if (rd_active_reg)
                begin
                    ram_raddr       = idx_reg;
                    pend_valid_next = 1'b1;
                    if (up_reg)
                    begin
                        pend_addr_next = idx_reg + IDX_W'(1);
                        if (idx_reg == tgt_reg)
                        begin
                            rd_active_next = 1'b0;
                        end
                        else
                        begin
                            idx_next = idx_reg - IDX_W'(1);
                        end
                    end
                    else
                    begin
                        pend_addr_next = idx_reg - IDX_W'(1);
                        if (idx_reg == last_idx)
                        begin
                            rd_active_next = 1'b0;
                        end
                        else
                        begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end
                end
                else
                begin
                    pend_valid_next = 1'b0;
                    if (up_reg)
                    begin
                        state_next = poos_pkg::ST_PLACE;
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = poos_pkg::ST_DONE;
                    end
                end
            end

            poos_pkg::ST_PLACE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = tgt_reg;
                wr_entry   = new_obj;
                count_next = full ? count_reg : count_reg + CNT_W'(1);
                state_next = poos_pkg::ST_DONE;
            end

            poos_pkg::ST_READ_WAIT:
            begin
                rword_next = rd_entry.word;
                state_next = poos_pkg::ST_DONE;
            end

            poos_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    res_next.status      = status_reg;
                    res_next.read_object = rword_reg;
                    res_next.entry_count = poos_pkg::COUNT_OUT_W'(count_reg);
                    out_valid_next       = 1'b1;
                    state_next           = poos_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = poos_pkg::ST_IDLE;
            end
        endcase
    end

    `POOS_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(SLOTS))
    `POOS_ASSERT_NEXT(a_accept_dispatch, accept, state_reg == poos_pkg::ST_DISPATCH)
    `POOS_ASSERT_SAME(a_shift_above_target,
        state_reg == poos_pkg::ST_MOVE && up_reg && rd_active_reg, idx_reg >= tgt_reg)
    `POOS_ASSERT_SAME(a_pend_in_range, pend_valid_reg, pend_addr_reg <= IDX_W'(SLOTS - 1))
    `POOS_ASSERT_SAME(a_count_only_while_busy,
        count_reg != $past(count_reg) && !$past(!rst_n),
        $past(state_reg) == poos_pkg::ST_DISPATCH || $past(state_reg) == poos_pkg::ST_MOVE
            || $past(state_reg) == poos_pkg::ST_PLACE)

endmodule

`default_nettype wire

### bench/priority_ordered_object_stack_checker.sv
`timescale 1ns / 100ps
// Checker for the priority-ordered object stack: watches the item, result and mode channels,
// keeps its own copy of the stack, and compares each result with the predicted one.
// Depends on poos_pkg for the item types and function codes.

module priority_ordered_object_stack_checker
    import poos_pkg::*;
#(
    parameter int SLOTS = 10
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data,
    input  logic      cfg_valid,
    input  logic      cfg_ready,
    input  logic      cfg_data,
    output int        pending,
    output int        fail_count
);

    entry_t      store [SLOTS];
    int unsigned fill;
    logic        modern;
    out_item_t   expected_outcomes [$];
    out_item_t   want;
    int          errs;

    function automatic int unsigned rank_of(entry_t e);
        return e.creature ? int'(CREATURE_PRIO) : int'(e.prio);
    endfunction

    function automatic void push_at(int unsigned at, entry_t e);
        int unsigned top_idx;
        int unsigned k;
        top_idx = (fill > SLOTS - 1) ? SLOTS - 1 : fill;
        for (k = top_idx; k > at; k--)
            store[k] = store[k - 1];
        store[at] = e;
        fill = top_idx + 1;
    endfunction

    function automatic out_item_t apply_stack_op(in_item_t it);
        out_item_t   r;
        entry_t      obj;
        int unsigned p;
        int unsigned q;
        int unsigned k;
        int unsigned idx;
        int unsigned pos;
        int unsigned limit;
        logic        strict;
        logic        placed;
        r = '0;
        obj.word = it.object_word;
        obj.prio = it.object_priority;
        obj.creature = it.is_creature;
        pos = it.position;
        case (it.func)
            FUNC_INSERT:
            begin
                if (it.at_top)
                begin
                    p = rank_of(obj);
                    strict = obj.creature && modern;
                    placed = 1'b0;
                    for (k = 0; k < fill && !placed; k++)
                    begin
                        q = rank_of(store[k]);
                        if (strict ? (q > p) : (q >= p))
                        begin
                            push_at(k, obj);
                            placed = 1'b1;
                        end
                    end
                    if (!placed && fill < SLOTS)
                    begin
                        store[fill] = obj;
                        fill++;
                    end
                end
                else if (pos > fill || pos >= SLOTS)
                    r.status = 1'b1;
                else
                    push_at(pos, obj);
            end
            FUNC_REMOVE, FUNC_READ:
            begin
                if (fill == 0)
                    r.status = 1'b1;
                else if (pos >= fill && modern)
                    r.status = 1'b1;
                else
                begin
                    idx = (pos >= fill) ? fill - 1 : pos;
                    if (it.func == FUNC_READ)
                        r.read_object = store[idx].word;
                    else
                    begin
                        for (k = idx; k + 1 < fill; k++)
                            store[k] = store[k + 1];
                        fill--;
                    end
                end
            end
            FUNC_OVERWRITE:
            begin
                limit = modern ? fill : SLOTS;
                if (pos >= limit)
                    r.status = 1'b1;
                else
                    store[pos] = obj;
            end
            FUNC_CLEAR:
                fill = 0;
            default:
                ;
        endcase
        r.entry_count = COUNT_OUT_W'(fill);
        return r;
    endfunction

    task automatic check_field(input string label, input logic [OBJECT_BITS-1:0] want_v,
                               input logic [OBJECT_BITS-1:0] got_v);
        if (got_v !== want_v)
        begin
            errs++;
            $error("%s mismatch: expected %0h, actual %0h", label, want_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                store[i] = '0;
            fill = 0;
            modern = 1'b0;
            expected_outcomes.delete();
            errs = 0;
            pending <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    errs++;
                    $error("result item arrived with none expected: %0h", out_data);
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    check_field("status", want.status, out_data.status);
                    check_field("read_object", want.read_object, out_data.read_object);
                    check_field("entry_count", want.entry_count, out_data.entry_count);
                end
            end
            if (cfg_valid && cfg_ready)
                modern = cfg_data;
            if (in_valid && in_ready)
                expected_outcomes.push_back(apply_stack_op(in_data));
            pending <= expected_outcomes.size();
            fail_count <= errs;
        end
    end

endmodule

### bench/priority_ordered_object_stack_tb.sv
`timescale 1ns / 100ps
// Testbench top for the priority-ordered object stack: clock, reset, item stimulus,
// result back-pressure and the verdict. Depends on poos_pkg, the block and its checker.

module priority_ordered_object_stack_tb;
    import poos_pkg::*;

    localparam int SLOTS = 10;
    localparam int RESET_CYCLES = 12;
    localparam int PHASES = 4;
    localparam int PHASE_ITEMS = 300;
    localparam int HOLD_AFTER = 150;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 2 * SLOTS + 10;
    localparam logic MODE_LEGACY = 1'b0;
    localparam logic MODE_MODERN = 1'b1;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = FUNC_CLEAR + 1;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = '1;

    typedef enum {DRAIN_FREE, DRAIN_COIN, DRAIN_SPARSE, DRAIN_TOGGLE} drain_style_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_data;
    int        pending;
    int        fail_count;
    int        burst_left;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    priority_ordered_object_stack #(
        .SLOTS(SLOTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    priority_ordered_object_stack_checker #(
        .SLOTS(SLOTS)
    ) checker_inst (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .fail_count (fail_count)
    );

    function automatic in_item_t random_op();
        in_item_t it;
        int       sel;
        sel = $urandom_range(0, 99);
        if (sel < 42)
            it.func = FUNC_INSERT;
        else if (sel < 58)
            it.func = FUNC_REMOVE;
        else if (sel < 72)
            it.func = FUNC_READ;
        else if (sel < 88)
            it.func = FUNC_OVERWRITE;
        else if (sel < 91)
            it.func = FUNC_CLEAR;
        else if (sel < 94)
            it.func = FUNC_W'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
        else
            it.func = FUNC_INSERT;
        it.at_top = $urandom_range(0, 1);
        if ($urandom_range(0, 4) == 0)
            it.position = POS_W'($urandom_range(0, 255));
        else
            it.position = POS_W'($urandom_range(0, SLOTS + 1));
        it.object_word = $urandom;
        if ($urandom_range(0, 1) == 0)
            it.object_priority = PRIO_W'($urandom_range(0, 8));
        else
            it.object_priority = PRIO_W'($urandom_range(0, 255));
        it.is_creature = ($urandom_range(0, 3) == 0);
        return it;
    endfunction

    task automatic issue(input in_item_t it);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 8);
        end
        in_data <= it;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        burst_left--;
    endtask

    task automatic op(input logic [FUNC_W-1:0] f, input logic by_prio,
                      input logic [POS_W-1:0] pos, input logic [OBJECT_BITS-1:0] word,
                      input logic [PRIO_W-1:0] prio, input logic creature);
        in_item_t it;
        it.func = f;
        it.at_top = by_prio;
        it.position = pos;
        it.object_word = word;
        it.object_priority = prio;
        it.is_creature = creature;
        issue(it);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic set_mode(input logic mode);
        drain();
        cfg_data <= mode;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        drain_style_t style;
        int           seen;
        int           hold_left;
        int           span;
        logic         nxt;
        seen = 0;
        hold_left = 0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            style = drain_style_t'($urandom_range(0, 3));
            span = $urandom_range(16, 120);
            repeat (span)
            begin
                @(posedge clk);
                if (out_valid && out_ready)
                begin
                    seen++;
                    if (seen == HOLD_AFTER)
                        hold_left = HOLD_CYCLES;
                end
                case (style)
                    DRAIN_FREE:   nxt = 1'b1;
                    DRAIN_COIN:   nxt = $urandom_range(0, 1);
                    DRAIN_SPARSE: nxt = ($urandom_range(0, 3) == 0);
                    default:      nxt = !out_ready;
                endcase
                if (hold_left > 0)
                begin
                    nxt = 1'b0;
                    hold_left--;
                end
                out_ready <= nxt;
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int k;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_data = MODE_LEGACY;
        burst_left = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        set_mode(MODE_LEGACY);
        op(FUNC_REMOVE, 1'b0, 0, 0, 0, 1'b0);
        op(FUNC_READ, 1'b0, 0, 0, 0, 1'b0);
        op(FUNC_INSERT, 1'b0, 1, 32'h1, 0, 1'b0);
        for (k = 0; k < SLOTS; k++)
            op(FUNC_INSERT, 1'b1, '1, (k == 0) ? '0 : (k == 1) ? '1 : $urandom,
               (k == 1) ? 8'hFF : PRIO_W'(k * 2), k == 3);
        op(FUNC_INSERT, 1'b1, 0, 32'hA5A5A5A5, 0, 1'b0);
        op(FUNC_INSERT, 1'b1, 0, 32'h5A5A5A5A, 8'hFF, 1'b0);
        op(FUNC_INSERT, 1'b0, SLOTS, $urandom, 3, 1'b0);
        op(FUNC_INSERT, 1'b0, 3, $urandom, 3, 1'b1);
        op(FUNC_READ, 1'b0, 8'hFF, 0, 0, 1'b0);
        op(FUNC_REMOVE, 1'b0, 200, 0, 0, 1'b0);
        op(FUNC_OVERWRITE, 1'b0, SLOTS - 1, 32'hFFFF0000, 8'hFF, 1'b1);
        op(FUNC_OVERWRITE, 1'b0, SLOTS, 32'h0000FFFF, 0, 1'b0);
        op(FUNC_SPARE_HI, 1'b1, 0, $urandom, 0, 1'b0);
        op(FUNC_CLEAR, 1'b0, 0, 0, 0, 1'b0);

        set_mode(MODE_MODERN);
        op(FUNC_INSERT, 1'b1, 0, 32'h11111111, CREATURE_PRIO, 1'b0);
        op(FUNC_INSERT, 1'b1, 0, 32'h22222222, 200, 1'b1);
        op(FUNC_READ, 1'b0, 1, 0, 0, 1'b0);
        op(FUNC_READ, 1'b0, 2, 0, 0, 1'b0);
        op(FUNC_REMOVE, 1'b0, 5, 0, 0, 1'b0);
        op(FUNC_OVERWRITE, 1'b0, 2, $urandom, 0, 1'b0);
        op(FUNC_OVERWRITE, 1'b0, 0, $urandom, 9, 1'b0);

        for (k = 0; k < PHASES; k++)
        begin
            set_mode((k % 2 == 0) ? MODE_MODERN : MODE_LEGACY);
            repeat (PHASE_ITEMS) issue(random_op());
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/poos_pkg.sv
rtl/core/poos_ram.sv
rtl/core/priority_ordered_object_stack.sv
bench/priority_ordered_object_stack_checker.sv
bench/priority_ordered_object_stack_tb.sv
